[src/hbap_pkg.sv]
package hbap_pkg;

    // Sizing
    localparam int NUM_BINS     = 24;
    localparam int COUNT_BITS   = 16;
    localparam int IDX_BITS     = $clog2(NUM_BINS);
    localparam int CMD_BITS     = 2;
    localparam int HOUR_BITS    = 5;
    localparam int VALUE_BITS   = 19;
    localparam int SAMPLES_BITS = 16;
    // |sum| < 2^(VALUE_BITS-1) * 2^COUNT_BITS, plus a sign bit
    localparam int SUM_BITS     = COUNT_BITS + VALUE_BITS;
    localparam int MAG_BITS     = SUM_BITS - 1;
    localparam int ENTRY_BITS   = SUM_BITS + COUNT_BITS;
    localparam int DIV_CNT_BITS = $clog2(MAG_BITS + 1);
    localparam int UPC_BITS     = 3;

    localparam logic signed [VALUE_BITS-1:0] MISSING_VALUE = -19'sd99900;
    localparam logic [COUNT_BITS-1:0]        COUNT_LIMIT   = {COUNT_BITS{1'b1}};

    // Command codes
    typedef enum logic [CMD_BITS-1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_REPORT = 2'd1,
        CMD_CLEAR  = 2'd2
    } cmd_t;

    // Sequencer branch conditions
    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_DISPATCH,
        C_DIV_MORE,
        C_MORE_BINS
    } cond_t;

    // Microcode addresses
    localparam logic [UPC_BITS-1:0] UA_IDLE  = UPC_BITS'(0);
    localparam logic [UPC_BITS-1:0] UA_S_WR  = UPC_BITS'(1);
    localparam logic [UPC_BITS-1:0] UA_R_RD  = UPC_BITS'(2);
    localparam logic [UPC_BITS-1:0] UA_R_LD  = UPC_BITS'(3);
    localparam logic [UPC_BITS-1:0] UA_R_DIV = UPC_BITS'(4);
    localparam logic [UPC_BITS-1:0] UA_R_EM  = UPC_BITS'(5);
    localparam logic [UPC_BITS-1:0] UA_R_END = UPC_BITS'(6);

    // One control word
    typedef struct packed {
        cond_t               cond;
        logic [UPC_BITS-1:0] target;
        logic                busy;
        logic                rd_idx;
        logic                wr_sample;
        logic                div_load;
        logic                div_step;
        logic                emit;
    } uword_t;

    // Control bundle from sequencer to datapath
    typedef struct packed {
        uword_t w;
        logic   accept;
        logic   clr_bins;
        logic   rpt_start;
    } ctrl_t;

    // Microprogram ROM
    function automatic uword_t ucode(input logic [UPC_BITS-1:0] addr);
        uword_t w;
        w        = '0;
        w.cond   = C_NEVER;
        w.target = UA_IDLE;
        case (addr)
            UA_IDLE: begin
                w.cond = C_DISPATCH;
            end
            UA_S_WR: begin
                w.cond      = C_ALWAYS;
                w.target    = UA_IDLE;
                w.busy      = 1'b1;
                w.wr_sample = 1'b1;
            end
            UA_R_RD: begin
                w.busy   = 1'b1;
                w.rd_idx = 1'b1;
            end
            UA_R_LD: begin
                w.busy     = 1'b1;
                w.rd_idx   = 1'b1;
                w.div_load = 1'b1;
            end
            UA_R_DIV: begin
                w.cond     = C_DIV_MORE;
                w.target   = UA_R_DIV;
                w.busy     = 1'b1;
                w.rd_idx   = 1'b1;
                w.div_step = 1'b1;
            end
            UA_R_EM: begin
                w.cond   = C_MORE_BINS;
                w.target = UA_R_RD;
                w.busy   = 1'b1;
                w.rd_idx = 1'b1;
                w.emit   = 1'b1;
            end
            UA_R_END: begin
                w.cond   = C_ALWAYS;
                w.target = UA_IDLE;
                w.busy   = 1'b1;
                w.rd_idx = 1'b1;
            end
            default: begin
                w.cond   = C_ALWAYS;
                w.target = UA_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

[src/hbap_ram.sv]
module hbap_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[src/hbap_div.sv]
module hbap_div
    import hbap_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  logic                  step,
    input  logic [MAG_BITS-1:0]   dividend,
    input  logic [COUNT_BITS-1:0] divisor,
    output logic [MAG_BITS-1:0]   quotient,
    output logic                  last_step
);

    logic [DIV_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [MAG_BITS-1:0]     quo_reg, quo_next;
    logic [COUNT_BITS-1:0]   rem_reg, rem_next;
    logic [COUNT_BITS-1:0]   dsr_reg, dsr_next;
    logic [COUNT_BITS:0]     rem_shift;
    logic [COUNT_BITS:0]     rem_diff;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[MAG_BITS-1]};
        rem_diff  = rem_shift - {1'b0, dsr_reg};
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (load)
        begin
            cnt_next = DIV_CNT_BITS'(MAG_BITS);
            quo_next = dividend;
            rem_next = '0;
            dsr_next = divisor;
        end
        else if (step && (cnt_reg != '0))
        begin
            cnt_next = cnt_reg - 1'b1;
            if (rem_shift >= {1'b0, dsr_reg})
            begin
                rem_next = rem_diff[COUNT_BITS-1:0];
                quo_next = {quo_reg[MAG_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[COUNT_BITS-1:0];
                quo_next = {quo_reg[MAG_BITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign quotient  = quo_reg;
    assign last_step = (cnt_reg == DIV_CNT_BITS'(1));

endmodule

[src/hbap_seq.sv]
module hbap_seq
    import hbap_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [CMD_BITS-1:0] cmd,
    input  logic                div_last,
    input  logic                more_bins,
    output ctrl_t               ctrl
);

    logic [UPC_BITS-1:0] upc_reg, upc_next;
    uword_t              word;

    assign word = ucode(upc_reg);

    // Next step address
    always_comb
    begin
        upc_next = upc_reg + 1'b1;
        case (word.cond)
            C_ALWAYS:
            begin
                upc_next = word.target;
            end
            C_DISPATCH:
            begin
                upc_next = UA_IDLE;
                if (start)
                begin
                    case (cmd)
                        CMD_SAMPLE: upc_next = UA_S_WR;
                        CMD_REPORT: upc_next = UA_R_RD;
                        default:    upc_next = UA_IDLE;
                    endcase
                end
            end
            C_DIV_MORE:
            begin
                if (!div_last)
                begin
                    upc_next = word.target;
                end
            end
            C_MORE_BINS:
            begin
                if (more_bins)
                begin
                    upc_next = word.target;
                end
            end
            default:
            begin
                upc_next = upc_reg + 1'b1;
            end
        endcase
    end

    // Control outputs
    always_comb
    begin
        ctrl.w         = word;
        ctrl.accept    = start && !word.busy;
        ctrl.clr_bins  = ctrl.accept && (cmd == CMD_CLEAR);
        ctrl.rpt_start = ctrl.accept && (cmd == CMD_REPORT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= UA_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

[src/hourly_bin_average_peak_finder_unit.sv]
// Channel  | Signals                                   | Transfer
// ---------+-------------------------------------------+---------------------------------
// command  | start, busy, cmd, hour, value             | start high while busy low
// result   | out_valid, bin_index, bin_average,        | out_valid high for one cycle,
//          | bin_samples, peak_hour, peak_average,     | taken at the edge ending it
//          | window_start, window_average, last        |
//
// A sample reads its bin, then does a read-modify-write; clear and unused commands end on accept.
// A report holds busy for one RAM read, a divider load, COUNT_BITS + 18 shift-subtract steps
// and one row per bin, then a final end step.
// Reset clears per-bin valid flags, so every bin reads as empty at once; no clearing pass.
// Results cannot be stalled; one row leaves per bin during a report.
module hourly_bin_average_peak_finder_unit
    import hbap_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [CMD_BITS-1:0]          cmd,
    input  logic [HOUR_BITS-1:0]         hour,
    input  logic signed [VALUE_BITS-1:0] value,
    output logic                         out_valid,
    output logic [HOUR_BITS-1:0]         bin_index,
    output logic signed [VALUE_BITS-1:0] bin_average,
    output logic [SAMPLES_BITS-1:0]      bin_samples,
    output logic [HOUR_BITS-1:0]         peak_hour,
    output logic signed [VALUE_BITS-1:0] peak_average,
    output logic [HOUR_BITS-1:0]         window_start,
    output logic signed [VALUE_BITS-1:0] window_average,
    output logic                         last
);

    ctrl_t ctrl;

    // Captured command
    logic [HOUR_BITS-1:0]         hour_reg;
    logic signed [VALUE_BITS-1:0] value_reg;

    // Bin storage
    logic [NUM_BINS-1:0]   valid_reg, valid_next;
    logic                  rd_valid_reg;
    logic [IDX_BITS-1:0]   rd_addr;
    logic [IDX_BITS-1:0]   wr_addr;
    logic [ENTRY_BITS-1:0] rd_data, wr_data;
    logic                  wr_en;
    logic signed [SUM_BITS-1:0] sum_eff, sum_new;
    logic [COUNT_BITS-1:0] cnt_eff;
    logic                  hour_ok;

    // Report datapath
    logic [IDX_BITS-1:0]          idx_reg;
    logic                         more_bins;
    logic                         neg_reg, zero_reg;
    logic [COUNT_BITS-1:0]        cnt_lat_reg;
    logic [MAG_BITS-1:0]          dividend, quotient;
    logic                         div_last;
    logic signed [VALUE_BITS-1:0] avg, q19;
    logic signed [VALUE_BITS-1:0] prev_avg_reg;
    logic signed [VALUE_BITS-1:0] peak_reg, peak_next;
    logic [IDX_BITS-1:0]          peak_bin_reg, peak_bin_next;
    logic signed [VALUE_BITS:0]   pair_sum;
    logic signed [VALUE_BITS:0]   best_reg, best_next;
    logic [IDX_BITS-1:0]          win_bin_reg, win_bin_next;

    // Output registers
    logic                         out_valid_reg;
    logic [HOUR_BITS-1:0]         bin_index_reg, peak_hour_reg, window_start_reg;
    logic signed [VALUE_BITS-1:0] bin_average_reg, peak_average_reg, window_average_reg;
    logic [SAMPLES_BITS-1:0]      bin_samples_reg;
    logic                         last_reg;

    hbap_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (cmd),
        .div_last  (div_last),
        .more_bins (more_bins),
        .ctrl      (ctrl)
    );

    // Read address: incoming hour while idle, scan index during a report
    assign hour_ok = (32'(hour) < NUM_BINS);
    assign rd_addr = ctrl.w.rd_idx ? idx_reg : (hour_ok ? IDX_BITS'(hour) : '0);

    hbap_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (NUM_BINS)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // Entry never written since reset or clear reads as zero
    assign sum_eff = rd_valid_reg ? $signed(rd_data[ENTRY_BITS-1:COUNT_BITS]) : '0;
    assign cnt_eff = rd_valid_reg ? rd_data[COUNT_BITS-1:0] : '0;

    // Sample update: skip out-of-range hours, missing data and full bins
    assign wr_addr = IDX_BITS'(hour_reg);
    assign wr_en   = ctrl.w.wr_sample && (32'(hour_reg) < NUM_BINS) &&
                     (value_reg != MISSING_VALUE) && (cnt_eff != COUNT_LIMIT);
    assign sum_new = sum_eff + SUM_BITS'(value_reg);
    assign wr_data = {sum_new, cnt_eff + 1'b1};

    always_comb
    begin
        valid_next = valid_reg;
        if (ctrl.clr_bins)
        begin
            valid_next = '0;
        end
        else if (wr_en)
        begin
            valid_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Valid flag follows the registered RAM read
    always_ff @(posedge clk)
    begin
        rd_valid_reg <= valid_reg[rd_addr];
        if (ctrl.accept)
        begin
            hour_reg  <= hour;
            value_reg <= value;
        end
    end

    // Divider on magnitudes, sign restored at the row
    assign dividend = sum_eff[SUM_BITS-1] ? MAG_BITS'(-sum_eff) : MAG_BITS'(sum_eff);

    hbap_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (ctrl.w.div_load),
        .step      (ctrl.w.div_step),
        .dividend  (dividend),
        .divisor   (cnt_eff),
        .quotient  (quotient),
        .last_step (div_last)
    );

    always_ff @(posedge clk)
    begin
        if (ctrl.w.div_load)
        begin
            neg_reg     <= sum_eff[SUM_BITS-1];
            zero_reg    <= (cnt_eff == '0);
            cnt_lat_reg <= cnt_eff;
        end
    end

    // Row average and running searches
    assign q19       = $signed(quotient[VALUE_BITS-1:0]);
    assign avg       = zero_reg ? '0 : (neg_reg ? -q19 : q19);
    assign more_bins = (32'(idx_reg) != NUM_BINS - 1);
    assign pair_sum  = (VALUE_BITS+1)'(prev_avg_reg) + (VALUE_BITS+1)'(avg);

    always_comb
    begin
        peak_next     = peak_reg;
        peak_bin_next = peak_bin_reg;
        best_next     = best_reg;
        win_bin_next  = win_bin_reg;
        if (avg > peak_reg)
        begin
            peak_next     = avg;
            peak_bin_next = idx_reg;
        end
        if ((idx_reg != '0) && (pair_sum > best_reg))
        begin
            best_next    = pair_sum;
            win_bin_next = idx_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else if (ctrl.rpt_start)
        begin
            idx_reg <= '0;
        end
        else if (ctrl.w.emit && more_bins)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.rpt_start)
        begin
            peak_reg     <= '0;
            peak_bin_reg <= '0;
            best_reg     <= '0;
            win_bin_reg  <= '0;
        end
        else if (ctrl.w.emit)
        begin
            peak_reg     <= peak_next;
            peak_bin_reg <= peak_bin_next;
            best_reg     <= best_next;
            win_bin_reg  <= win_bin_next;
            prev_avg_reg <= avg;
        end
    end

    // Result row strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= ctrl.w.emit;
        end
    end

    // Result row payload; summary fields only on the final row
    always_ff @(posedge clk)
    begin
        if (ctrl.w.emit)
        begin
            bin_index_reg   <= HOUR_BITS'(idx_reg);
            bin_average_reg <= avg;
            bin_samples_reg <= SAMPLES_BITS'(cnt_lat_reg);
            last_reg        <= !more_bins;
            if (!more_bins)
            begin
                peak_hour_reg      <= HOUR_BITS'(peak_bin_next);
                peak_average_reg   <= peak_next;
                window_start_reg   <= HOUR_BITS'(win_bin_next);
                window_average_reg <= best_next[VALUE_BITS:1];
            end
            else
            begin
                peak_hour_reg      <= '0;
                peak_average_reg   <= '0;
                window_start_reg   <= '0;
                window_average_reg <= '0;
            end
        end
    end

    assign busy           = ctrl.w.busy;
    assign out_valid      = out_valid_reg;
    assign bin_index      = bin_index_reg;
    assign bin_average    = bin_average_reg;
    assign bin_samples    = bin_samples_reg;
    assign peak_hour      = peak_hour_reg;
    assign peak_average   = peak_average_reg;
    assign window_start   = window_start_reg;
    assign window_average = window_average_reg;
    assign last           = last_reg;

endmodule
